// ----- hw/rtl/multistep_attack_tracker_macros.svh -----
// ---------------------------------------------------------------------------
// multistep_attack_tracker_macros.svh
// Assertion macros for the multistep attack tracker.
// ---------------------------------------------------------------------------
`ifndef MULTISTEP_ATTACK_TRACKER_MACROS_SVH
`define MULTISTEP_ATTACK_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define MAT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define MAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define MAT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/mat_pkg.sv -----
// ---------------------------------------------------------------------------
// mat_pkg
// Types and constants shared by the multistep attack tracker.
// ---------------------------------------------------------------------------
package mat_pkg;

  localparam int HOST_W = 32;
  localparam int KIND_W = 2;

  typedef enum logic [KIND_W-1:0] {
    EV_AUTH     = 2'd0,
    EV_HTTP_ZIP = 2'd1,
    EV_FTP_ZIP  = 2'd2,
    EV_OTHER    = 2'd3
  } event_kind_t;

  // Lookup request as it walks down the cell row.
  typedef struct packed {
    logic              vld;
    event_kind_t       kind;
    logic [HOST_W-1:0] host;
    logic              hit;
    logic              free_seen;
    logic              alarm;
  } req_t;

  typedef struct packed {
    logic              alarm;
    logic [HOST_W-1:0] alarm_host;
    logic              table_full;
    logic              bad_event;
  } result_t;

endpackage

// ----- hw/rtl/mat_if.sv -----
// ---------------------------------------------------------------------------
// mat_if
// Valid/ready channels for events and results of the attack tracker.
// ---------------------------------------------------------------------------
interface mat_in_if;
  import mat_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [HOST_W-1:0] source_host;
  logic [HOST_W-1:0] dest_host;

  modport source (output valid, event_kind, source_host, dest_host, input ready);
  modport sink   (input valid, event_kind, source_host, dest_host, output ready);
endinterface

interface mat_out_if;
  import mat_pkg::*;

  logic              valid;
  logic              ready;
  logic              alarm;
  logic [HOST_W-1:0] alarm_host;
  logic              table_full;
  logic              bad_event;

  modport source (output valid, alarm, alarm_host, table_full, bad_event, input ready);
  modport sink   (input valid, alarm, alarm_host, table_full, bad_event, output ready);
endinterface

// ----- hw/rtl/multistep_attack_tracker.sv -----
// A result passes from the last slot cell to the pending register, then to the output
// register. The input takes one event at a time: the request walks the row of slot
// cells one cell per cycle, and no new event is taken while it is in the row.
// A pending result blocks the input until the output register takes it.
// Reset (synchronous, active low) clears all slot valid bits and request valids at once.
// ---------------------------------------------------------------------------
// multistep_attack_tracker
// Per-host three-stage intrusion tracker over a row of associative slot cells.
// ---------------------------------------------------------------------------
`include "multistep_attack_tracker_macros.svh"

module multistep_attack_tracker #(
  parameter int TABLE_DEPTH = 64
) (
  input logic      clk,
  input logic      rst_n,
  mat_in_if.sink   in_ch,
  mat_out_if.source out_ch
);
  import mat_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  req_t                   chain [TABLE_DEPTH+1];
  logic [IDX_W-1:0]       fidx  [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] vld_vec;

  logic              in_acc;
  event_kind_t       in_kind;
  logic              busy_r, busy_nxt;
  logic              pend_r, pend_nxt;
  result_t           pend_res_r, pend_res_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;
  logic              out_load;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  logic [HOST_W-1:0] wr_host;
  req_t              tail;

  always_comb begin
    in_acc             = in_ch.valid && in_ch.ready;
    in_kind            = event_kind_t'(in_ch.event_kind);
    chain[0]           = '0;
    chain[0].vld       = in_acc;
    chain[0].kind      = in_kind;
    chain[0].host      = (in_kind == EV_AUTH) ? in_ch.source_host : in_ch.dest_host;
    fidx[0]            = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    mat_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .req_i      (chain[i]),
      .free_idx_i (fidx[i]),
      .req_o      (chain[i+1]),
      .free_idx_o (fidx[i+1]),
      .wr_en      (wr_en),
      .wr_idx     (wr_idx),
      .wr_host    (wr_host)
    );
    assign vld_vec[i] = chain[i+1].vld;
  end

  assign tail = chain[TABLE_DEPTH];

  always_comb begin
    // commit the insert into the lowest free slot once the whole row was searched
    wr_en   = tail.vld && (tail.kind == EV_AUTH) && !tail.hit && tail.free_seen;
    wr_idx  = fidx[TABLE_DEPTH];
    wr_host = tail.host;

    out_load = pend_r && (!out_valid_r || out_ch.ready);

    busy_nxt = busy_r;
    if (in_acc) busy_nxt = 1'b1;
    else if (tail.vld) busy_nxt = 1'b0;

    pend_res_nxt = pend_res_r;
    pend_nxt     = pend_r;
    if (tail.vld) begin
      pend_nxt                = 1'b1;
      pend_res_nxt.alarm      = tail.alarm;
      pend_res_nxt.alarm_host = tail.alarm ? tail.host : '0;
      pend_res_nxt.table_full = (tail.kind == EV_AUTH) && !tail.hit && !tail.free_seen;
      pend_res_nxt.bad_event  = (tail.kind == EV_OTHER);
    end else if (out_load) begin
      pend_nxt = 1'b0;
    end

    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = pend_res_r;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_res_r <= pend_res_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign in_ch.ready       = !busy_r && !pend_r;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.alarm      = out_res_r.alarm;
  assign out_ch.alarm_host = out_res_r.alarm_host;
  assign out_ch.table_full = out_res_r.table_full;
  assign out_ch.bad_event  = out_res_r.bad_event;

  `MAT_ASSERT_IMPLIES(a_one_request, clk, rst_n, 1'b1, $onehot0(vld_vec))
  `MAT_ASSERT_NEXT(a_accept_enters_row, clk, rst_n, in_ch.valid && in_ch.ready, vld_vec[0])
  `MAT_ASSERT_NEXT(a_tail_to_pend, clk, rst_n, tail.vld, pend_r)
  `MAT_ASSERT_IMPLIES(a_alarm_alone, clk, rst_n, pend_r && pend_res_r.alarm,
                      !pend_res_r.table_full && !pend_res_r.bad_event)

endmodule

// ----- hw/rtl/mat_cell.sv -----
// ---------------------------------------------------------------------------
// mat_cell
// One table slot: compares the passing request, updates its own entry and
// hands the request on to the next slot.
// ---------------------------------------------------------------------------
module mat_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mat_pkg::req_t             req_i,
  input  logic [IDX_W-1:0]          free_idx_i,
  output mat_pkg::req_t             req_o,
  output logic [IDX_W-1:0]          free_idx_o,
  input  logic                      wr_en,
  input  logic [IDX_W-1:0]          wr_idx,
  input  logic [mat_pkg::HOST_W-1:0] wr_host
);
  import mat_pkg::*;

  logic              valid_r, valid_nxt;
  logic [HOST_W-1:0] host_r, host_nxt;
  logic              stage_r, stage_nxt;
  req_t              req_r, req_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              match;
  logic              wr_hit;

  always_comb begin
    match     = req_i.vld && valid_r && (host_r == req_i.host);
    wr_hit    = wr_en && (wr_idx == IDX_W'(CELL_IDX));
    valid_nxt = valid_r;
    host_nxt  = host_r;
    stage_nxt = stage_r;
    req_nxt   = req_i;
    idx_nxt   = free_idx_i;

    if (wr_hit) begin
      valid_nxt = 1'b1;
      host_nxt  = wr_host;
      stage_nxt = 1'b0;
    end

    if (match) begin
      req_nxt.hit = 1'b1;
      case (req_i.kind)
        EV_HTTP_ZIP: begin
          if (!stage_r) stage_nxt = 1'b1;
        end
        EV_FTP_ZIP: begin
          // complete the sequence: free the slot
          if (stage_r) begin
            valid_nxt     = 1'b0;
            req_nxt.alarm = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // note the lowest free slot
    if (req_i.vld && !valid_r && !req_i.free_seen) begin
      req_nxt.free_seen = 1'b1;
      idx_nxt           = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      req_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      req_r   <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    host_r  <= host_nxt;
    stage_r <= stage_nxt;
    idx_r   <= idx_nxt;
  end

  assign req_o      = req_r;
  assign free_idx_o = idx_r;

endmodule
